[rtl/uvib_pkg.sv]
// Shared types and constants of the unified vertex index builder.
package uvib_pkg;

    // Widths of the fixed stream fields.
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned VN_W        = 16;
    localparam int unsigned S_TDATA_W   = 3 * IDX_W;
    localparam int unsigned S_TUSER_W   = 1;
    localparam int unsigned M_TDATA_W   = VN_W;
    localparam int unsigned M_TUSER_W   = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the incoming corner
        logic scan;      // issue the next table read
        logic take_hit;  // record the matching entry
        logic emit;      // write the result register, insert if needed
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;       // entry read last cycle matches the key
        logic scan_end;  // all valid entries were read and compared
        logic out_free;  // result register can take a new result
    } t_dp_stat;

endpackage

[rtl/unified_vertex_index_builder.sv]
// Top level of the unified vertex index builder: stream ports, controller and datapath.
//
// The block turns each triangle corner (one-based position, normal and texture
// indices) into a unified vertex number for an index buffer. One is subtracted
// from each index, the three values wrapped to INDEX_BITS form a key, and the
// key is looked up among the keys stored for the current mesh. A known key
// returns the number it was given when first stored; an unseen key is stored
// under the next number and the result carries is_new. Setting new_mesh on a
// corner empties the table before that corner is handled. Once MAX_VERTICES
// keys are stored, an unseen key is dropped and the result is vertex number 0
// with overflow set; keys already stored are still found. The table is scanned
// through the single read port of one RAM, one entry per clock. A corner that
// matches a stored entry ends the scan at that entry; a key that is not found is
// first compared with every stored entry. One corner is handled at a time. The
// finished result sits in an output register, so the next corner is taken while
// the previous result still waits for its transfer; only a result that finds the
// register still occupied stalls the block until that transfer. No clearing pass
// is needed after reset.
module unified_vertex_index_builder #(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned INDEX_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input corner stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata, lowest bit up: pos_index[15:0], normal_index[31:16], uv_index[47:32].
    input  logic [uvib_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: new_mesh[0].
    input  logic [uvib_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: vertex_number[15:0].
    output logic [uvib_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser, lowest bit up: is_new[0], overflow[1].
    output logic [uvib_pkg::M_TUSER_W-1:0]   m_tuser
);

    uvib_pkg::t_dp_cmd  cmd;
    uvib_pkg::t_dp_stat stat;
    logic               is_new;
    logic               overflow;

    // The controller only decides when to capture, scan, stop and emit; all
    // storage and comparison live in the datapath.
    uvib_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    uvib_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .INDEX_BITS   (INDEX_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_new_mesh      (s_tuser[0]),
        .i_pos_index     (s_tdata[uvib_pkg::IDX_W-1:0]),
        .i_normal_index  (s_tdata[2*uvib_pkg::IDX_W-1:uvib_pkg::IDX_W]),
        .i_uv_index      (s_tdata[3*uvib_pkg::IDX_W-1:2*uvib_pkg::IDX_W]),
        .o_out_valid     (m_tvalid),
        .i_out_ready     (m_tready),
        .o_vertex_number (m_tdata),
        .o_is_new        (is_new),
        .o_overflow      (overflow)
    );

    assign m_tuser = {overflow, is_new};

endmodule

[rtl/uvib_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module uvib_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/uvib_ctrl.sv]
// Controller state machine that sequences capture, table scan and result output.
module uvib_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  uvib_pkg::t_dp_stat i_stat,
    output uvib_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_in_valid && r_ready;
            end
            ST_SEARCH: begin
                o_cmd.take_hit = i_stat.hit;
                o_cmd.scan     = !i_stat.hit && !i_stat.scan_end;
            end
            ST_FINISH: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= ST_SEARCH;
                        r_ready <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    if (i_stat.hit || i_stat.scan_end) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (i_stat.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_ready;

endmodule

[rtl/uvib_dp.sv]
// Datapath: key register, vertex count, scan counter, key table and result register.
module uvib_dp #(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned INDEX_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  uvib_pkg::t_dp_cmd            i_cmd,
    output uvib_pkg::t_dp_stat           o_stat,
    input  logic                         i_new_mesh,
    input  logic [uvib_pkg::IDX_W-1:0]   i_pos_index,
    input  logic [uvib_pkg::IDX_W-1:0]   i_normal_index,
    input  logic [uvib_pkg::IDX_W-1:0]   i_uv_index,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [uvib_pkg::VN_W-1:0]    o_vertex_number,
    output logic                         o_is_new,
    output logic                         o_overflow
);

    localparam int unsigned KEY_W  = 3 * INDEX_BITS;
    localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

    logic [KEY_W-1:0]          n_key;
    logic [KEY_W-1:0]          r_key;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_issue;
    logic                      r_cmp_valid;
    logic [ADDR_W-1:0]         r_cmp_addr;
    logic                      r_found;
    logic [ADDR_W-1:0]         r_hit_addr;
    logic                      r_out_valid;
    logic [uvib_pkg::VN_W-1:0] r_out_number;
    logic                      r_out_new;
    logic                      r_out_ovf;

    logic             issue_done;
    logic             full;
    logic             rd_en;
    logic             wr_en;
    logic [KEY_W-1:0] rd_data;

    // Each component is the one-based index minus one, wrapped to INDEX_BITS.
    assign n_key = {INDEX_BITS'(i_pos_index - 1'b1),
                    INDEX_BITS'(i_normal_index - 1'b1),
                    INDEX_BITS'(i_uv_index - 1'b1)};

    assign issue_done = (r_issue == r_count);
    assign full       = (r_count == CNT_W'(MAX_VERTICES));
    assign rd_en      = i_cmd.scan && !issue_done;
    assign wr_en      = i_cmd.emit && !r_found && !full;

    assign o_stat.hit      = r_cmp_valid && (rd_data == r_key);
    assign o_stat.scan_end = issue_done && !r_cmp_valid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    uvib_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_VERTICES)
    ) u_key_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_issue     <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_key       <= n_key;
                r_issue     <= '0;
                r_cmp_valid <= 1'b0;
                r_found     <= 1'b0;
                if (i_new_mesh) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.scan) begin
                r_cmp_valid <= !issue_done;
                if (!issue_done) begin
                    r_issue    <= CNT_W'(r_issue + 1'b1);
                    r_cmp_addr <= r_issue[ADDR_W-1:0];
                end
            end
            if (i_cmd.take_hit) begin
                r_found     <= 1'b1;
                r_hit_addr  <= r_cmp_addr;
                r_cmp_valid <= 1'b0;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_found) begin
                    r_out_number <= uvib_pkg::VN_W'(r_hit_addr);
                    r_out_new    <= 1'b0;
                    r_out_ovf    <= 1'b0;
                end else if (!full) begin
                    r_out_number <= uvib_pkg::VN_W'(r_count);
                    r_out_new    <= 1'b1;
                    r_out_ovf    <= 1'b0;
                    r_count      <= CNT_W'(r_count + 1'b1);
                end else begin
                    r_out_number <= '0;
                    r_out_new    <= 1'b0;
                    r_out_ovf    <= 1'b1;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_vertex_number = r_out_number;
    assign o_is_new        = r_out_new;
    assign o_overflow      = r_out_ovf;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count exceeds table depth");

    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_valid |-> (CNT_W'(r_cmp_addr) < r_count))
        else $error("compared a table entry that was never written");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result written while previous result still pending");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_new && r_out_ovf))
        else $error("result flagged both new and overflow");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insertion did not advance the vertex count");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for the unified vertex index builder.

typedef struct packed {
    logic [15:0] vertex_number;
    logic        is_new;
    logic        overflow;
} t_vertex_result;

// Keeps its own copy of the mesh key table and the queue of vertex numbers still owed by
// the block.
class vertex_scoreboard;
    int unsigned    table_depth;
    logic [47:0]    mesh_keys[$];
    t_vertex_result owed_results[$];
    int unsigned    error_count;

    function new(int unsigned depth);
        table_depth = depth;
        error_count = 0;
    endfunction

    task report_mismatch(string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    // Called for every corner transfer taken by the block.
    function void note_corner(logic new_mesh, logic [15:0] pos, logic [15:0] nrm,
                              logic [15:0] uv);
        logic [15:0]    kp;
        logic [15:0]    kn;
        logic [15:0]    kt;
        logic [47:0]    key;
        t_vertex_result res;
        int             hit_at;
        kp = pos - 16'd1;
        kn = nrm - 16'd1;
        kt = uv - 16'd1;
        key = {kp, kn, kt};
        if (new_mesh) begin
            mesh_keys.delete();
        end
        hit_at = -1;
        foreach (mesh_keys[i]) begin
            if (hit_at < 0 && mesh_keys[i] == key) begin
                hit_at = i;
            end
        end
        res = '0;
        if (hit_at >= 0) begin
            res.vertex_number = 16'(hit_at);
        end else if (mesh_keys.size() < table_depth) begin
            res.vertex_number = 16'(mesh_keys.size());
            res.is_new = 1'b1;
            mesh_keys = {mesh_keys, key};
        end else begin
            res.overflow = 1'b1;
        end
        owed_results = {owed_results, res};
    endfunction

    // Called for every result transfer; compares it with the oldest owed result.
    task check_result(logic [15:0] vertex_number, logic is_new, logic overflow);
        t_vertex_result want;
        if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d new=%b ovf=%b",
                                      vertex_number, is_new, overflow));
        end else begin
            want = owed_results.pop_front();
            if (vertex_number !== want.vertex_number) begin
                report_mismatch($sformatf("vertex_number %0d, wanted %0d",
                                          vertex_number, want.vertex_number));
            end
            if (is_new !== want.is_new) begin
                report_mismatch($sformatf("is_new %b, wanted %b (vertex %0d)",
                                          is_new, want.is_new, want.vertex_number));
            end
            if (overflow !== want.overflow) begin
                report_mismatch($sformatf("overflow %b, wanted %b (vertex %0d)",
                                          overflow, want.overflow, want.vertex_number));
            end
        end
    endtask

    function bit nothing_owed();
        return owed_results.size() == 0;
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned TABLE_DEPTH    = 1024;
    // Wait margin for one corner that scans the whole table.
    localparam int unsigned SCAN_LATENCY   = TABLE_DEPTH + 4;
    localparam int unsigned CYCLE_LIMIT    = 6_000_000;
    localparam int unsigned FILL_CORNERS   = 300;
    localparam int unsigned RANDOM_CORNERS = 250;
    localparam int unsigned MAX_POOL       = 64;
    localparam int unsigned IDLE_PERCENT   = 28;
    // The long receiver hold falls inside the random phase, after the fill phase.
    localparam int unsigned HOLD_AT_RESULT = 420;
    localparam int unsigned HOLD_CYCLES    = 4000;
    localparam int unsigned RX_CALM_FROM   = 470;
    localparam int unsigned RX_CALM_TO     = 550;
    localparam int unsigned TX_CALM_FROM   = 60;
    localparam int unsigned TX_CALM_TO     = 180;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [uvib_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [uvib_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [uvib_pkg::M_TDATA_W-1:0] m_tdata;
    logic [uvib_pkg::M_TUSER_W-1:0] m_tuser;

    vertex_scoreboard scoreboard;
    bit               tx_may_idle = 1'b1;
    bit               rx_hold     = 1'b0;
    int unsigned      results_taken = 0;
    int unsigned      cycle_count   = 0;

    // Keys used to fill the table, kept so that stored keys can be replayed later.
    logic [15:0] fill_pos[FILL_CORNERS];
    logic [15:0] fill_nrm[FILL_CORNERS];
    logic [15:0] fill_uv[FILL_CORNERS];
    // Corner pool of one random mesh; corners reuse pool entries like a real mesh does.
    logic [15:0] pool_pos[MAX_POOL];
    logic [15:0] pool_nrm[MAX_POOL];
    logic [15:0] pool_uv[MAX_POOL];

    unified_vertex_index_builder #(
        .MAX_VERTICES(TABLE_DEPTH),
        .INDEX_BITS  (16)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Index values lean on the extremes: zero (wraps to all ones), one, and the largest.
    function automatic logic [15:0] pick_index();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll == 0) begin
            return 16'd0;
        end else if (roll == 1) begin
            return 16'd1;
        end else if (roll == 2) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Offers one corner, after a random idle gap, and waits for its transfer.
    task automatic send_corner(logic new_mesh, logic [15:0] pos, logic [15:0] nrm,
                               logic [15:0] uv);
        while (tx_may_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= new_mesh;
        s_tdata  <= {uv, nrm, pos};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        scoreboard.note_corner(new_mesh, pos, nrm, uv);
    endtask

    // Holds the receiver off once for a long stretch so that the block backs up and
    // stalls its input.
    initial begin
        wait (results_taken >= HOLD_AT_RESULT);
        @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Receiver: checks each result transfer and idles at random.
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) begin
                scoreboard.check_result(m_tdata, m_tuser[0], m_tuser[1]);
                results_taken++;
            end
            m_tready <= !rx_hold
                        && ((results_taken >= RX_CALM_FROM && results_taken < RX_CALM_TO)
                            || ($urandom_range(99) >= IDLE_PERCENT));
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned random_sent;
        int unsigned pool_size;
        int unsigned corners;
        int unsigned roll;
        int unsigned pick;
        logic        mesh_flag;

        scoreboard = new(TABLE_DEPTH);
        random_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners. The first mesh starts right after reset without new_mesh.
        send_corner(1'b0, 16'd1, 16'd1, 16'd1);
        send_corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_corner(1'b0, 16'd0, 16'd0, 16'd0);         // every index wraps to all ones
        send_corner(1'b0, 16'd1, 16'd1, 16'd1);         // known key
        send_corner(1'b0, 16'd0, 16'd0, 16'd0);
        send_corner(1'b0, 16'd0, 16'd1, 16'hFFFF);
        send_corner(1'b0, 16'd1, 16'd0, 16'hFFFF);
        send_corner(1'b0, 16'hFFFF, 16'd1, 16'd0);
        send_corner(1'b0, 16'h8000, 16'h5555, 16'hAAAA);
        send_corner(1'b0, 16'hAAAA, 16'h5555, 16'h8000);
        send_corner(1'b0, 16'hFFFF, 16'd1, 16'd0);      // known key, stored before the last two
        send_corner(1'b1, 16'd0, 16'd0, 16'd0);         // new mesh starts at vertex zero
        send_corner(1'b0, 16'd1, 16'd1, 16'd1);
        send_corner(1'b1, 16'd0, 16'd0, 16'd0);         // new mesh on a key just seen
        send_corner(1'b0, 16'd0, 16'd0, 16'd0);
        send_corner(1'b0, 16'd1, 16'd1, 16'd1);
        send_corner(1'b1, 16'h5555, 16'hAAAA, 16'h7FFF);
        send_corner(1'b0, 16'h5555, 16'hAAAA, 16'h7FFF);

        // Fill a large part of the table. Distinct position indices keep all keys unique;
        // the last one uses index zero.
        for (int i = 0; i < FILL_CORNERS; i++) begin
            fill_pos[i] = (i == FILL_CORNERS - 1) ? 16'd0 : 16'(i + 1);
            fill_nrm[i] = 16'($urandom);
            fill_uv[i]  = 16'($urandom);
            send_corner(i == 0, fill_pos[i], fill_nrm[i], fill_uv[i]);
        end
        // Stored keys are found deep in the table and unseen keys are appended.
        send_corner(1'b0, fill_pos[FILL_CORNERS-1], fill_nrm[FILL_CORNERS-1],
                    fill_uv[FILL_CORNERS-1]);
        send_corner(1'b0, 16'd2000, 16'd7, 16'd9);
        send_corner(1'b0, fill_pos[0], fill_nrm[0], fill_uv[0]);
        send_corner(1'b0, 16'd0, fill_nrm[FILL_CORNERS-1] + 16'd1, fill_uv[FILL_CORNERS-1]);
        for (int i = 0; i < 4; i++) begin
            send_corner(1'b0, 16'($urandom_range(FILL_CORNERS + 1, 65535)), 16'($urandom),
                        16'($urandom));
            pick = $urandom_range(FILL_CORNERS - 1);
            send_corner(1'b0, fill_pos[pick], fill_nrm[pick], fill_uv[pick]);
        end
        send_corner(1'b0, 16'd2000, 16'd7, 16'd9);      // the appended key is now known
        send_corner(1'b1, 16'd2000, 16'd7, 16'd9);      // and starts over once the table empties

        // Random meshes: mostly corners reused from a small pool, some noise corners and a
        // few meshes broken by a stray new_mesh or continued without one.
        while (random_sent < RANDOM_CORNERS) begin
            pool_size = ($urandom_range(9) == 0) ? $urandom_range(25, MAX_POOL)
                                                 : $urandom_range(1, 12);
            for (int k = 0; k < pool_size; k++) begin
                pool_pos[k] = pick_index();
                pool_nrm[k] = pick_index();
                pool_uv[k]  = pick_index();
            end
            corners = $urandom_range(pool_size, 3 * pool_size + 2);
            for (int c = 0; c < corners && random_sent < RANDOM_CORNERS; c++) begin
                tx_may_idle = !(random_sent >= TX_CALM_FROM && random_sent < TX_CALM_TO);
                roll = $urandom_range(99);
                if (c == 0) begin
                    mesh_flag = ($urandom_range(9) != 0);
                end else begin
                    mesh_flag = (roll < 3);
                end
                if (roll >= 3 && roll < 12) begin
                    send_corner(mesh_flag, pick_index(), pick_index(), pick_index());
                end else begin
                    pick = $urandom_range(pool_size - 1);
                    send_corner(mesh_flag, pool_pos[pick], pool_nrm[pick], pool_uv[pick]);
                end
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (!scoreboard.nothing_owed()) begin
            @(posedge i_clk);
        end
        repeat (SCAN_LATENCY + 8) @(posedge i_clk);
        if (scoreboard.error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
